// ===== sv/rhhsv_pkg.sv =====
`timescale 1ns / 1ps
package rhhsv_pkg;

    // default number of fraction bits of the hue format
    localparam int HUE_FRAC_BITS_DEF = 6;

    localparam int HUE_STEP_W = 15;
    localparam logic [HUE_STEP_W-1:0] HUE_STEP_RST = 15'd320;

    // source pixel
    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_pix_in;

    // source HSV triple and rotated pixel
    typedef struct packed {
        logic [14:0] hue_angle;
        logic [7:0]  saturation_frac;
        logic [7:0]  value_level;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
    } t_pix_out;

    // values that ride along with the dividers
    typedef struct packed {
        logic [7:0] mx;
        logic       dl_zero;
        logic       mx_zero;
    } t_div_side;

endpackage

// ===== sv/rhhsv_div.sv =====
`timescale 1ns / 1ps
module rhhsv_div #(
    parameter int NW = 23
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [NW-1:0]         i_num_a,
    input  logic [7:0]            i_den_a,
    input  logic [NW-1:0]         i_num_b,
    input  logic [7:0]            i_den_b,
    input  rhhsv_pkg::t_div_side  i_side,
    output logic                  o_vld,
    output logic [NW-1:0]         o_quo_a,
    output logic [NW-1:0]         o_quo_b,
    output rhhsv_pkg::t_div_side  o_side
);
    import rhhsv_pkg::*;

    // one restoring step per stage, two dividers in lockstep
    logic [NW-1:0] w_acc_a [NW+1];
    logic [NW-1:0] w_acc_b [NW+1];
    logic [7:0]    w_rem_a [NW+1];
    logic [7:0]    w_rem_b [NW+1];
    logic [7:0]    w_den_a [NW+1];
    logic [7:0]    w_den_b [NW+1];
    t_div_side     w_side  [NW+1];
    logic          w_vld   [NW+1];

    assign w_acc_a[0] = i_num_a;
    assign w_acc_b[0] = i_num_b;
    assign w_rem_a[0] = 8'd0;
    assign w_rem_b[0] = 8'd0;
    assign w_den_a[0] = i_den_a;
    assign w_den_b[0] = i_den_b;
    assign w_side[0]  = i_side;
    assign w_vld[0]   = i_vld;

    for (genvar j = 0; j < NW; j++) begin : g_step
        logic [8:0]    n_ta, n_tb;
        logic          n_ga, n_gb;
        logic [NW-1:0] r_acc_a, r_acc_b;
        logic [7:0]    r_rem_a, r_rem_b, r_den_a, r_den_b;
        t_div_side     r_side;
        logic          r_vld;

        // shift in the next numerator bit and try to subtract
        always_comb begin
            n_ta = {w_rem_a[j], w_acc_a[j][NW-1]};
            n_tb = {w_rem_b[j], w_acc_b[j][NW-1]};
            n_ga = n_ta >= {1'b0, w_den_a[j]};
            n_gb = n_tb >= {1'b0, w_den_b[j]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc_a <= {w_acc_a[j][NW-2:0], n_ga};
                r_acc_b <= {w_acc_b[j][NW-2:0], n_gb};
                r_rem_a <= n_ga ? 8'(n_ta - {1'b0, w_den_a[j]}) : n_ta[7:0];
                r_rem_b <= n_gb ? 8'(n_tb - {1'b0, w_den_b[j]}) : n_tb[7:0];
                r_den_a <= w_den_a[j];
                r_den_b <= w_den_b[j];
                r_side  <= w_side[j];
            end
        end

        assign w_acc_a[j+1] = r_acc_a;
        assign w_acc_b[j+1] = r_acc_b;
        assign w_rem_a[j+1] = r_rem_a;
        assign w_rem_b[j+1] = r_rem_b;
        assign w_den_a[j+1] = r_den_a;
        assign w_den_b[j+1] = r_den_b;
        assign w_side[j+1]  = r_side;
        assign w_vld[j+1]   = r_vld;
    end

    assign o_vld   = w_vld[NW];
    assign o_quo_a = w_acc_a[NW];
    assign o_quo_b = w_acc_b[NW];
    assign o_side  = w_side[NW];

endmodule

// ===== sv/rgb_hue_rotation_via_hsv_core.sv =====
`timescale 1ns / 1ps
// Hue rotation of an RGB pixel stream through HSV.
// Input channel: i_in_valid / o_in_ready with one 8-bit RGB pixel per item.
// Output channel: o_out_valid / i_out_ready with the source hue (degrees
// times 2^HUE_FRAC_BITS), saturation (Q0.8), value, and the pixel after the
// hue has been advanced by hue_step and wrapped at 360 degrees.
// hue_step is written through the APB port at byte address 0; pready is
// always high and reads with paddr[2] clear return the register.
// Throughput: one item per clock while the output is not stalled. The hue
// divider is bit-per-stage, with depth equal to the numerator width, and
// sits between two front and eight back stages.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so a stalled receiver freezes every stage and no
// item is lost or repeated; o_in_ready drops during the stall.
// Reset empties the pipeline and sets hue_step to 320 (5 degrees).
module rgb_hue_rotation_via_hsv_core #(
    parameter int HUE_FRAC_BITS = rhhsv_pkg::HUE_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rhhsv_pkg::t_pix_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rhhsv_pkg::t_pix_out o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import rhhsv_pkg::*;

    localparam int F    = HUE_FRAC_BITS;
    localparam int P    = 60 << F;
    localparam int FT   = 360 << F;
    localparam int HW   = $clog2(FT);
    localparam int PW   = $clog2(P + 1);
    localparam int NUMW = HW + 8;
    localparam int XW   = ((HW > HUE_STEP_W) ? HW : HUE_STEP_W) + 1;
    localparam int YW   = XW - 3 - F;
    localparam int RECIP45 = 23301;
    localparam int RECIP15 = 4369;
    localparam logic REG_HUE_STEP = 1'b0;

    typedef enum logic [1:0] {BASE_ZERO, BASE_TURN, BASE_TWO, BASE_FOUR} t_base;
    typedef enum logic [2:0] {SECT_0, SECT_1, SECT_2, SECT_3, SECT_4, SECT_5} t_sector;

    logic en;
    logic [HUE_STEP_W-1:0] r_hue_step;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_step <= HUE_STEP_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_HUE_STEP) begin
            r_hue_step <= pwdata[HUE_STEP_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_HUE_STEP) ? {{(32-HUE_STEP_W){1'b0}}, r_hue_step} : '0;

    // advance all stages when the output register frees up
    logic r_out_vld;
    assign en          = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_vld;

    // stage A: max, min, delta and sector of the hue formula
    logic [7:0]        n_mx, n_mn;
    t_base             n_base;
    logic signed [8:0] n_diff;
    logic              r_a_vld;
    logic [7:0]        r_a_mx, r_a_dl;
    t_base             r_a_base;
    logic signed [8:0] r_a_diff;

    always_comb begin
        n_mx = i_in_data.in_red;
        n_mn = i_in_data.in_red;
        if (i_in_data.in_green > n_mx) n_mx = i_in_data.in_green;
        if (i_in_data.in_blue > n_mx)  n_mx = i_in_data.in_blue;
        if (i_in_data.in_green < n_mn) n_mn = i_in_data.in_green;
        if (i_in_data.in_blue < n_mn)  n_mn = i_in_data.in_blue;
        if (n_mx == i_in_data.in_red) begin
            n_base = (i_in_data.in_green >= i_in_data.in_blue) ? BASE_ZERO : BASE_TURN;
            n_diff = $signed({1'b0, i_in_data.in_green}) - $signed({1'b0, i_in_data.in_blue});
        end else if (n_mx == i_in_data.in_green) begin
            n_base = BASE_TWO;
            n_diff = $signed({1'b0, i_in_data.in_blue}) - $signed({1'b0, i_in_data.in_red});
        end else begin
            n_base = BASE_FOUR;
            n_diff = $signed({1'b0, i_in_data.in_red}) - $signed({1'b0, i_in_data.in_green});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_mx   <= n_mx;
            r_a_dl   <= 8'(n_mx - n_mn);
            r_a_base <= n_base;
            r_a_diff <= n_diff;
        end
    end

    // stage B: hue numerator base*delta + P*diff
    logic [HW-1:0]        n_base_v;
    logic [HW+7:0]        n_prod;
    logic signed [PW+9:0] n_pd;
    logic signed [HW+9:0] n_num;
    logic                 r_b_vld;
    logic [NUMW-1:0]      r_b_num;
    logic [7:0]           r_b_mx, r_b_dl;

    always_comb begin
        case (r_a_base)
            BASE_ZERO: n_base_v = '0;
            BASE_TURN: n_base_v = HW'(FT);
            BASE_TWO:  n_base_v = HW'(2 * P);
            BASE_FOUR: n_base_v = HW'(4 * P);
            default:   n_base_v = '0;
        endcase
        n_prod = n_base_v * r_a_dl;
        n_pd   = $signed({1'b0, PW'(P)}) * r_a_diff;
        n_num  = $signed({2'b00, n_prod}) + (HW+10)'(n_pd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_num <= n_num[NUMW-1:0];
            r_b_mx  <= r_a_mx;
            r_b_dl  <= r_a_dl;
        end
    end

    // hue and saturation dividers
    t_div_side       n_side, d_side;
    logic            d_vld;
    logic [NUMW-1:0] d_quo_a, d_quo_b;

    assign n_side = '{mx: r_b_mx, dl_zero: (r_b_dl == 8'd0), mx_zero: (r_b_mx == 8'd0)};

    rhhsv_div #(.NW(NUMW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_b_vld),
        .i_num_a (r_b_num),
        .i_den_a (r_b_dl),
        .i_num_b (NUMW'({r_b_dl, 8'd0})),
        .i_den_b (r_b_mx),
        .i_side  (n_side),
        .o_vld   (d_vld),
        .o_quo_a (d_quo_a),
        .o_quo_b (d_quo_b),
        .o_side  (d_side)
    );

    // P1: grey and black cases, clamp saturation, add hue step
    logic [HW-1:0] n_hue;
    logic [7:0]    n_sat;
    logic          r1_vld;
    logic [XW-1:0] r1_x;
    t_pix_out      r1_hsv;

    always_comb begin
        n_hue = d_side.dl_zero ? '0 : d_quo_a[HW-1:0];
        if (d_side.mx_zero)         n_sat = 8'd0;
        else if (|d_quo_b[NUMW-1:8]) n_sat = 8'd255;
        else                        n_sat = d_quo_b[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= d_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x   <= XW'(n_hue) + XW'(r_hue_step);
            r1_hsv <= '{hue_angle: 15'(n_hue), saturation_frac: n_sat,
                        value_level: d_side.mx, default: '0};
        end
    end

    // P2: estimate turns by reciprocal of 45 on x / 2^(3+F)
    logic [YW+14:0] n_rq;
    logic           r2_vld;
    logic [7:0]     r2_q;
    logic [XW-1:0]  r2_x;
    t_pix_out       r2_hsv;

    assign n_rq = r1_x[XW-1:3+F] * 15'(RECIP45);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_q   <= 8'(n_rq >> 20);
            r2_x   <= r1_x;
            r2_hsv <= r1_hsv;
        end
    end

    // P3: subtract whole turns, correct by one turn
    logic [XW-1:0] n_h0;
    logic [HW-1:0] n_h;
    logic          r3_vld;
    logic [HW-1:0] r3_h;
    t_pix_out      r3_hsv;

    always_comb begin
        n_h0 = r2_x - XW'(r2_q * FT);
        n_h  = (n_h0 >= XW'(FT)) ? HW'(n_h0 - XW'(FT)) : HW'(n_h0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_h   <= n_h;
            r3_hsv <= r2_hsv;
        end
    end

    // P4: sector and weight inside it
    logic [2:0]    n_k;
    logic [HW-1:0] n_q;
    logic          r4_vld;
    t_sector       r4_sec;
    logic [PW-1:0] r4_w;
    t_pix_out      r4_hsv;

    always_comb begin
        n_k = 3'd0;
        for (int s = 1; s < 6; s++) begin
            if (r3_h >= HW'(s * P)) n_k = 3'(s);
        end
        n_q = r3_h - HW'(n_k * P);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sec <= t_sector'(n_k);
            r4_w   <= n_k[0] ? PW'(PW'(P) - PW'(n_q)) : PW'(n_q);
            r4_hsv <= r3_hsv;
        end
    end

    // P5: s*(P-w) and the min channel
    logic [16:0]   n_lo;
    logic          r5_vld;
    t_sector       r5_sec;
    logic [PW+7:0] r5_t;
    logic [7:0]    r5_lo;
    t_pix_out      r5_hsv;

    assign n_lo = r4_hsv.value_level * (9'd256 - {1'b0, r4_hsv.saturation_frac});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_sec <= r4_sec;
            r5_t   <= r4_hsv.saturation_frac * (PW'(P) - r4_w);
            r5_lo  <= n_lo[15:8];
            r5_hsv <= r4_hsv;
        end
    end

    // P6: V * (256P - s*(P-w))
    logic           r6_vld;
    t_sector        r6_sec;
    logic [PW+15:0] r6_m;
    logic [7:0]     r6_lo;
    t_pix_out       r6_hsv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_sec <= r5_sec;
            r6_m   <= r5_hsv.value_level * ((PW+8)'(P << 8) - r5_t);
            r6_lo  <= r5_lo;
            r6_hsv <= r5_hsv;
        end
    end

    // P7: divide by 2^(10+F), then estimate /15 by reciprocal
    logic [11:0] n_y2;
    logic [24:0] n_p2;
    logic        r7_vld;
    t_sector     r7_sec;
    logic [11:0] r7_y2;
    logic [8:0]  r7_q2;
    logic [7:0]  r7_lo;
    t_pix_out    r7_hsv;

    always_comb begin
        n_y2 = 12'(r6_m >> (10 + F));
        n_p2 = n_y2 * 13'(RECIP15);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_sec <= r6_sec;
            r7_y2  <= n_y2;
            r7_q2  <= n_p2[24:16];
            r7_lo  <= r6_lo;
            r7_hsv <= r6_hsv;
        end
    end

    // P8: correct the middle channel and order channels by sector
    logic [11:0] n_rem;
    logic [7:0]  n_mid, n_v;
    t_pix_out    n_out;
    t_pix_out    r_out;

    always_comb begin
        n_rem = r7_y2 - 12'(r7_q2 * 15);
        n_mid = (n_rem >= 12'd15) ? 8'(r7_q2 + 9'd1) : r7_q2[7:0];
        n_v   = r7_hsv.value_level;
        n_out = r7_hsv;
        case (r7_sec)
            SECT_0:  {n_out.out_red, n_out.out_green, n_out.out_blue} = {n_v, n_mid, r7_lo};
            SECT_1:  {n_out.out_red, n_out.out_green, n_out.out_blue} = {n_mid, n_v, r7_lo};
            SECT_2:  {n_out.out_red, n_out.out_green, n_out.out_blue} = {r7_lo, n_v, n_mid};
            SECT_3:  {n_out.out_red, n_out.out_green, n_out.out_blue} = {r7_lo, n_mid, n_v};
            SECT_4:  {n_out.out_red, n_out.out_green, n_out.out_blue} = {n_mid, r7_lo, n_v};
            SECT_5:  {n_out.out_red, n_out.out_green, n_out.out_blue} = {n_v, r7_lo, n_mid};
            default: {n_out.out_red, n_out.out_green, n_out.out_blue} = {n_v, r7_lo, n_mid};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r7_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule
